// ----- hw/rtl/mat_pkg.sv -----
// ----------------------------------------------------------------------------
// mat_pkg
// Shared constants, codes and types of the multi-alarm timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package mat_pkg;

  localparam int NUM_ALARMS  = 8;
  localparam int TICK_MS     = 10;
  localparam int MAX_RESULTS = 8;

  localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam int DELAY_W   = 31;
  localparam int EVENT_W   = 8;
  localparam int AUX_W     = 32;
  localparam int ELAPSED_W = 32;
  localparam int KIND_W    = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REQ,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // request word as latched on acceptance
  typedef struct packed {
    logic [DELAY_W-1:0] delay_ms;
    logic               periodic;
    logic [EVENT_W-1:0] event_id;
    logic [AUX_W-1:0]   aux_data;
  } req_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // latch request word, clear scan index and counter
    logic req_exec;   // carry out the latched request and emit its word
    logic scan_step;  // handle the entry under the scan index, advance
    logic flush;      // emit the held firing as the final word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halted;
    logic step_ok;     // scan step can complete this cycle
    logic scan_last;   // scan index on the final entry
    logic pend_valid;  // a firing is held back
    logic out_free;    // output register can take a word this cycle
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mat_if.sv -----
// ----------------------------------------------------------------------------
// mat_if
// Valid/ready channels carrying request words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mat_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [mat_pkg::DELAY_W-1:0]  delay_ms;
  logic                         periodic;
  logic [mat_pkg::EVENT_W-1:0]  event_id;
  logic [mat_pkg::AUX_W-1:0]    aux_data;

  modport source (output valid, action, delay_ms, periodic, event_id, aux_data,
                  input ready);
  modport sink   (input valid, action, delay_ms, periodic, event_id, aux_data,
                  output ready);
endinterface

interface mat_out_if;
  logic                         valid;
  logic                         ready;
  logic [mat_pkg::KIND_W-1:0]   kind;
  logic [mat_pkg::EVENT_W-1:0]  fired_event;
  logic [mat_pkg::AUX_W-1:0]    fired_aux;
  logic                         last;

  modport source (output valid, kind, fired_event, fired_aux, last,
                  input ready);
  modport sink   (input valid, kind, fired_event, fired_aux, last,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mat_ctrl.sv -----
// ----------------------------------------------------------------------------
// mat_ctrl
// Sequencer: takes one word at a time and steps the datapath through a
// request or through a scan of the alarm table.
// ----------------------------------------------------------------------------
`default_nettype none

module mat_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_action,
  output logic                  in_ready,
  input  mat_pkg::status_t      status,
  output mat_pkg::cmd_t         cmd
);

  mat_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mat_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      mat_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_action) begin
            state_nxt = mat_pkg::ST_REQ;
          end else if (!status.halted) begin
            state_nxt = mat_pkg::ST_SCAN;
          end
        end
      end
      mat_pkg::ST_REQ: begin
        if (status.out_free) begin
          cmd.req_exec = 1'b1;
          state_nxt    = mat_pkg::ST_IDLE;
        end
      end
      mat_pkg::ST_SCAN: begin
        if (status.step_ok) begin
          cmd.scan_step = 1'b1;
          if (status.scan_last) begin
            state_nxt = mat_pkg::ST_FLUSH;
          end
        end
      end
      mat_pkg::ST_FLUSH: begin
        if (!status.pend_valid) begin
          state_nxt = mat_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = mat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mat_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mat_dpath.sv -----
// ----------------------------------------------------------------------------
// mat_dpath
// Alarm table, request latch, scan index, held firing and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mat_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  mat_pkg::cmd_t                      cmd,
  output mat_pkg::status_t                   status,
  input  mat_pkg::req_t                      in_req,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mat_pkg::KIND_W-1:0]         out_kind,
  output logic [mat_pkg::EVENT_W-1:0]        out_fired_event,
  output logic [mat_pkg::AUX_W-1:0]          out_fired_aux,
  output logic                               out_last
);

  localparam int N = mat_pkg::NUM_ALARMS;

  // table
  logic [N-1:0]                      active_r;
  logic [N-1:0]                      periodic_r;
  logic [mat_pkg::DELAY_W-1:0]       delay_r   [N];
  logic [mat_pkg::EVENT_W-1:0]       event_r   [N];
  logic [mat_pkg::AUX_W-1:0]         aux_r     [N];
  logic [mat_pkg::ELAPSED_W-1:0]     elapsed_r [N];
  logic                              halted_r;

  mat_pkg::req_t                     req_r;
  logic [mat_pkg::IDX_W-1:0]         idx_r;
  logic [mat_pkg::CNT_W-1:0]         cnt_r;

  logic                              pend_valid_r;
  logic [mat_pkg::EVENT_W-1:0]       pend_event_r;
  logic [mat_pkg::AUX_W-1:0]         pend_aux_r;

  logic                              out_valid_r;
  logic [mat_pkg::KIND_W-1:0]        out_kind_r;
  logic [mat_pkg::EVENT_W-1:0]       out_event_r;
  logic [mat_pkg::AUX_W-1:0]         out_aux_r;
  logic                              out_last_r;

  // request decode
  logic                              is_cancel;
  logic                              free_found;
  logic [mat_pkg::IDX_W-1:0]         free_idx;
  logic [N-1:0]                      cancel_hit;

  // scan of the current entry
  logic [mat_pkg::ELAPSED_W:0]       sum;
  logic [mat_pkg::ELAPSED_W-1:0]     e_sat;
  logic                              cur_active;
  logic                              cur_fire;
  logic                              out_free;

  // output push
  logic                              push;
  mat_pkg::kind_t                    push_kind;
  logic [mat_pkg::EVENT_W-1:0]       push_event;
  logic [mat_pkg::AUX_W-1:0]         push_aux;
  logic                              push_last;

  assign is_cancel = (req_r.delay_ms == '0) && !req_r.periodic;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = mat_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cancel_hit[i] = active_r[i] && (event_r[i] == req_r.event_id);
    end
  end

  // saturating elapsed advance
  assign sum   = {1'b0, elapsed_r[idx_r]} + (mat_pkg::ELAPSED_W + 1)'(mat_pkg::TICK_MS);
  assign e_sat = sum[mat_pkg::ELAPSED_W] ? '1 : sum[mat_pkg::ELAPSED_W-1:0];

  assign cur_active = active_r[idx_r];
  assign cur_fire   = cur_active &&
                      ({1'b0, delay_r[idx_r]} <= e_sat) &&
                      (cnt_r < mat_pkg::CNT_W'(mat_pkg::MAX_RESULTS));
  assign out_free   = !out_valid_r || out_ready;

  assign status.halted     = halted_r;
  assign status.step_ok    = !(cur_fire && pend_valid_r && !out_free);
  assign status.scan_last  = (idx_r == mat_pkg::IDX_W'(N - 1));
  assign status.pend_valid = pend_valid_r;
  assign status.out_free   = out_free;

  always_comb begin
    push       = 1'b0;
    push_kind  = mat_pkg::KIND_FIRED;
    push_event = pend_event_r;
    push_aux   = pend_aux_r;
    push_last  = 1'b0;
    if (cmd.req_exec) begin
      push       = 1'b1;
      push_event = '0;
      push_aux   = '0;
      push_last  = 1'b1;
      if (halted_r || (!is_cancel && !free_found)) begin
        push_kind = mat_pkg::KIND_ERROR;
      end else begin
        push_kind = mat_pkg::KIND_DONE;
      end
    end else if (cmd.scan_step && cur_fire && pend_valid_r) begin
      push = 1'b1;
    end else if (cmd.flush) begin
      push      = 1'b1;
      push_last = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      halted_r     <= 1'b0;
      idx_r        <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.accept) begin
        idx_r        <= '0;
        cnt_r        <= '0;
        pend_valid_r <= 1'b0;
      end

      if (cmd.req_exec && !halted_r) begin
        if (is_cancel) begin
          active_r <= active_r & ~cancel_hit;
        end else if (free_found) begin
          active_r[free_idx] <= 1'b1;
        end else begin
          halted_r <= 1'b1;
        end
      end

      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (cur_fire) begin
          cnt_r        <= cnt_r + 1'b1;
          pend_valid_r <= 1'b1;
          if (!periodic_r[idx_r]) begin
            active_r[idx_r] <= 1'b0;
          end
        end
      end

      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_req;
    end

    if (cmd.req_exec && !halted_r && !is_cancel && free_found) begin
      periodic_r[free_idx] <= req_r.periodic;
      delay_r[free_idx]    <= req_r.delay_ms;
      event_r[free_idx]    <= req_r.event_id;
      aux_r[free_idx]      <= req_r.aux_data;
      elapsed_r[free_idx]  <= '0;
    end

    if (cmd.scan_step && cur_active) begin
      if (cur_fire) begin
        elapsed_r[idx_r] <= '0;
        pend_event_r     <= event_r[idx_r];
        pend_aux_r       <= aux_r[idx_r];
      end else begin
        elapsed_r[idx_r] <= e_sat;
      end
    end

    if (push) begin
      out_kind_r  <= push_kind;
      out_event_r <= push_event;
      out_aux_r   <= push_aux;
      out_last_r  <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_fired_event = out_event_r;
  assign out_fired_aux   = out_aux_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/multi_alarm_timer_table_top.sv -----
// ----------------------------------------------------------------------------
// multi_alarm_timer_table_top
// Table of one-shot and periodic alarms driven by request and tick words.
// ----------------------------------------------------------------------------
// Request: accepted in idle, carried out once the output register is free,
//   its result word registered. Tick: one table entry per cycle while the
//   output does not stall, scanned in index order, then a final flush.
// One word in flight at a time; a result may wait while the next is taken.
// Synchronous active-low reset frees all entries and clears the halt.
`default_nettype none

module multi_alarm_timer_table_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mat_in_if.sink     in_ch,
  mat_out_if.source  out_ch
);

  mat_pkg::cmd_t    cmd;
  mat_pkg::status_t status;
  mat_pkg::req_t    in_req;
  logic             in_ready;

  assign in_req.delay_ms = in_ch.delay_ms;
  assign in_req.periodic = in_ch.periodic;
  assign in_req.event_id = in_ch.event_id;
  assign in_req.aux_data = in_ch.aux_data;
  assign in_ch.ready     = in_ready;

  mat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mat_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_req          (in_req),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_fired_event (out_ch.fired_event),
    .out_fired_aux   (out_ch.fired_aux),
    .out_last        (out_ch.last)
  );

endmodule

`default_nettype wire

// ----- tb/mat_alarm_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// mat_alarm_tb_pkg
// Scoreboard of the alarm timer table bench. It keeps its own copy of the
// alarm table, predicts the result words of every accepted word and checks
// the words that the block returns, in order.
// ----------------------------------------------------------------------------
package mat_alarm_tb_pkg;

  import mat_pkg::*;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_REQ  = 1'b1;

  localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;

  typedef struct packed {
    kind_t              kind;
    logic [EVENT_W-1:0] fired_event;
    logic [AUX_W-1:0]   fired_aux;
    logic               last;
  } alarm_word_t;

  class alarm_table_checker;

    bit                   slot_used     [NUM_ALARMS];
    bit                   slot_periodic [NUM_ALARMS];
    logic [DELAY_W-1:0]   slot_delay    [NUM_ALARMS];
    logic [EVENT_W-1:0]   slot_event    [NUM_ALARMS];
    logic [AUX_W-1:0]     slot_aux      [NUM_ALARMS];
    logic [ELAPSED_W-1:0] slot_elapsed  [NUM_ALARMS];
    bit                   halted;
    alarm_word_t          due_words[$];
    int unsigned          n_errors;

    function new();
      for (int i = 0; i < NUM_ALARMS; i++) begin
        slot_used[i]     = 1'b0;
        slot_periodic[i] = 1'b0;
        slot_delay[i]    = '0;
        slot_event[i]    = '0;
        slot_aux[i]      = '0;
        slot_elapsed[i]  = '0;
      end
      halted   = 1'b0;
      n_errors = 0;
    endfunction

    // works out the words that one accepted input word causes
    function void note_word(logic action, req_t r);
      alarm_word_t          w;
      int                   free_slot;
      int                   fired;
      logic [ELAPSED_W-1:0] e;
      w.kind        = KIND_DONE;
      w.fired_event = '0;
      w.fired_aux   = '0;
      w.last        = 1'b1;
      if (action == ACT_REQ) begin
        if (halted) begin
          w.kind = KIND_ERROR;
        end else if (r.delay_ms == '0 && !r.periodic) begin
          // cancel: frees every match, answered even when nothing matched
          for (int i = 0; i < NUM_ALARMS; i++)
            if (slot_used[i] && slot_event[i] == r.event_id) slot_used[i] = 1'b0;
        end else begin
          free_slot = -1;
          for (int i = 0; i < NUM_ALARMS; i++)
            if (!slot_used[i] && free_slot < 0) free_slot = i;
          if (free_slot < 0) begin
            halted = 1'b1;
            w.kind = KIND_ERROR;
          end else begin
            slot_used[free_slot]     = 1'b1;
            slot_periodic[free_slot] = r.periodic;
            slot_delay[free_slot]    = r.delay_ms;
            slot_event[free_slot]    = r.event_id;
            slot_aux[free_slot]      = r.aux_data;
            slot_elapsed[free_slot]  = '0;
          end
        end
        due_words.push_back(w);
      end else if (!halted) begin
        fired = 0;
        for (int i = 0; i < NUM_ALARMS; i++) begin
          if (!slot_used[i]) continue;
          e = slot_elapsed[i];
          e = (e > ELAPSED_TOP - TICK_MS) ? ELAPSED_TOP : e + TICK_MS;
          slot_elapsed[i] = e;
          if ({1'b0, slot_delay[i]} <= e && fired < MAX_RESULTS) begin
            w.kind        = KIND_FIRED;
            w.fired_event = slot_event[i];
            w.fired_aux   = slot_aux[i];
            w.last        = 1'b0;
            due_words.push_back(w);
            fired++;
            if (slot_periodic[i]) slot_elapsed[i] = '0;
            else slot_used[i] = 1'b0;
          end
        end
        if (fired > 0) due_words[due_words.size()-1].last = 1'b1;
      end
    endfunction

    function void check_word(alarm_word_t got);
      alarm_word_t want;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d event %02h aux %08h last %0d",
                 $time, got.kind, got.fired_event, got.fired_aux, got.last);
        n_errors++;
        return;
      end
      want = due_words.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
        n_errors++;
      end
      if (got.fired_event != want.fired_event) begin
        $display("%0t: fired_event expected %02h, got %02h",
                 $time, want.fired_event, got.fired_event);
        n_errors++;
      end
      if (got.fired_aux != want.fired_aux) begin
        $display("%0t: fired_aux expected %08h, got %08h",
                 $time, want.fired_aux, got.fired_aux);
        n_errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

    function int unsigned slots_in_use();
      int unsigned n;
      n = 0;
      for (int i = 0; i < NUM_ALARMS; i++) if (slot_used[i]) n++;
      return n;
    endfunction

    // event id of some armed entry, or any id when the table is empty
    function logic [EVENT_W-1:0] pick_armed_event();
      int idx[$];
      for (int i = 0; i < NUM_ALARMS; i++) if (slot_used[i]) idx.push_back(i);
      if (idx.size() == 0) return EVENT_W'($urandom);
      return slot_event[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

  endclass

endpackage

// ----- tb/multi_alarm_timer_table_top_tb.sv -----
// ----------------------------------------------------------------------------
// multi_alarm_timer_table_top_tb
// Drives tick, arm and cancel words into the alarm timer table and checks
// every result word against the scoreboard: a directed opening, a long
// random run with gaps and stalls on both sides, then the overflow halt.
// ----------------------------------------------------------------------------
module multi_alarm_timer_table_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mat_pkg::*;
  import mat_alarm_tb_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AFTER   = 120;  // result words seen before the long stall
  localparam int HOLD_CYCLES  = 300;

  logic clk;
  logic rst_n;

  mat_in_if  in_ch ();
  mat_out_if out_ch ();

  multi_alarm_timer_table_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alarm_table_checker table_chk = new();
  bit                 steady    = 1'b0;  // no gaps on either side
  int unsigned        words_out = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_out >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  initial begin
    alarm_word_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind        = kind_t'(out_ch.kind);
        got.fired_event = out_ch.fired_event;
        got.fired_aux   = out_ch.fired_aux;
        got.last        = out_ch.last;
        words_out++;
        table_chk.check_word(got);
      end
    end
  end

  task automatic send_word(input logic action, input logic [DELAY_W-1:0] delay,
                           input logic per, input logic [EVENT_W-1:0] ev,
                           input logic [AUX_W-1:0] aux);
    req_t r;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= action;
    in_ch.delay_ms <= delay;
    in_ch.periodic <= per;
    in_ch.event_id <= ev;
    in_ch.aux_data <= aux;
    do @(posedge clk); while (!in_ch.ready);
    r.delay_ms = delay;
    r.periodic = per;
    r.event_id = ev;
    r.aux_data = aux;
    table_chk.note_word(action, r);
  endtask

  // request fields are don't-care on a tick, so fill them with noise
  task automatic tick_word();
    send_word(ACT_TICK, DELAY_W'($urandom), 1'($urandom), EVENT_W'($urandom), $urandom);
  endtask

  task automatic arm_word(input logic [DELAY_W-1:0] delay, input logic per,
                          input logic [EVENT_W-1:0] ev, input logic [AUX_W-1:0] aux);
    send_word(ACT_REQ, delay, per, ev, aux);
  endtask

  task automatic cancel_word(input logic [EVENT_W-1:0] ev);
    send_word(ACT_REQ, '0, 1'b0, ev, $urandom);
  endtask

  initial begin
    int unsigned        roll;
    logic [DELAY_W-1:0] delay;
    logic               per;
    logic [EVENT_W-1:0] ev;

    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_TICK;
    in_ch.delay_ms = '0;
    in_ch.periodic = 1'b0;
    in_ch.event_id = '0;
    in_ch.aux_data = '0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening
    tick_word();                                   // empty table, no word back
    cancel_word(8'h00);                            // cancel with no match
    arm_word(31'd10, 1'b0, 8'hFF, 32'hFFFF_FFFF);
    tick_word();
    arm_word('0, 1'b1, 8'h00, 32'h0000_0000);      // periodic, zero delay
    tick_word();
    tick_word();
    arm_word(31'h7FFF_FFFF, 1'b0, 8'hA5, 32'h8000_0000);
    arm_word(31'd25, 1'b0, 8'h5A, 32'h1234_5678);
    tick_word();
    tick_word();
    tick_word();
    cancel_word(8'h00);
    cancel_word(8'hA5);
    // full table, every entry due on one tick
    for (int i = 0; i < NUM_ALARMS; i++)
      if (i % 2 == 0) arm_word('0, 1'b1, 8'h3C, 32'(i));
      else arm_word(31'd10, 1'b0, 8'h3C, ~32'(i));
    tick_word();
    tick_word();
    cancel_word(8'h3C);
    tick_word();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 150 && n < 220);
      if (n == 300) begin
        // drop the last word first so the pause cannot resend it
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (table_chk.pending() != 0) @(posedge clk);
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        tick_word();
      end else if (roll < 65 || table_chk.slots_in_use() == NUM_ALARMS) begin
        if ($urandom_range(0, 3) == 0) cancel_word(EVENT_W'($urandom));
        else cancel_word(table_chk.pick_armed_event());
      end else begin
        per   = 1'($urandom);
        delay = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom)
                                            : DELAY_W'($urandom_range(0, 60));
        ev    = ($urandom_range(0, 3) == 0) ? EVENT_W'($urandom)
                                            : EVENT_W'($urandom_range(1, 6));
        arm_word(delay, per, ev, $urandom);
      end
    end
    steady = 1'b0;

    // fill with alarms that never come due, then overflow; halt is final
    while (table_chk.slots_in_use() < NUM_ALARMS)
      arm_word(31'h7FFF_FFFF, 1'b0, EVENT_W'($urandom), $urandom);
    arm_word(31'd20, 1'b1, 8'h11, 32'hDEAD_BEEF);
    arm_word(31'd5, 1'b0, 8'h22, $urandom);
    cancel_word(8'h11);
    tick_word();
    tick_word();
    arm_word('0, 1'b1, 8'h33, $urandom);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (table_chk.pending() != 0) @(posedge clk);
    repeat (4 * (NUM_ALARMS + 2)) @(posedge clk);
    if (table_chk.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
